[hdl/pipt_pkg.sv]
// types, codes and the quarter-wave sine table for the park / inverse park block
// no dependencies; imported by every module of the block

package pipt_pkg;

  localparam int unsigned DataWidth = 16;
  localparam int unsigned RomDepth  = 256;
  localparam int unsigned RomWidth  = 15;

  // pi in unsigned q60
  localparam logic [63:0] PiQ60 = 64'h3243F6A8885A308D;

  typedef enum logic {
    KIND_FWD = 1'b0,
    KIND_INV = 1'b1
  } pipt_kind_e;

  typedef struct packed {
    pipt_kind_e                   kind;
    logic signed [DataWidth-1:0] first_in;
    logic signed [DataWidth-1:0] second_in;
    logic signed [DataWidth-1:0] angle;
  } pipt_in_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] first_out;
    logic signed [DataWidth-1:0] second_out;
  } pipt_out_t;

  typedef logic [RomDepth-1:0][RomWidth-1:0] pipt_rom_t;

  // sin(i*pi/512) in q15, taylor series in q62, round half up, limited to 32767
  function automatic pipt_rom_t build_sin_rom();
    pipt_rom_t    rom;
    logic [63:0]  step;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [63:0]  v;
    logic [127:0] prod;
    int           i;
    int           k;
    step = PiQ60 >> 7;
    for (i = 0; i < int'(RomDepth); i++) begin
      x    = step * 64'(i);
      prod = {64'd0, x} * {64'd0, x};
      x2   = prod[125:62];
      term = x;
      sum  = x;
      for (k = 1; k <= 14; k++) begin
        prod = {64'd0, term} * {64'd0, x2};
        term = prod[125:62] / 64'((2 * k) * (2 * k + 1));
        if (k[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum + (64'd1 << 46)) >> 47;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      rom[i] = v[RomWidth-1:0];
    end
    return rom;
  endfunction

  localparam pipt_rom_t SinRom = build_sin_rom();

endpackage

[hdl/pipt_sincos.sv]
// sine and cosine of a q1.15 angle from the quarter-wave table
// depends on pipt_pkg

module pipt_sincos (
  input  logic signed [pipt_pkg::DataWidth-1:0] angle_i,
  output logic signed [pipt_pkg::DataWidth-1:0] sin_o,
  output logic signed [pipt_pkg::DataWidth-1:0] cos_o
);
  import pipt_pkg::*;

  // quadrant codes after the half-turn offset
  localparam logic [1:0] QuadNegHigh = 2'd0;  // -180 .. -90
  localparam logic [1:0] QuadNegLow  = 2'd1;  // -90 .. 0
  localparam logic [1:0] QuadPosLow  = 2'd2;  // 0 .. 90
  localparam logic [1:0] QuadPosHigh = 2'd3;  // 90 .. 180

  logic [1:0]                  quad;
  logic [7:0]                  low;
  logic [7:0]                  mir;
  logic signed [DataWidth-1:0] rom_low;
  logic signed [DataWidth-1:0] rom_mir;

  // adding a half turn flips the sign bit; the index is the top ten bits
  assign quad = {~angle_i[DataWidth-1], angle_i[DataWidth-2]};
  assign low  = angle_i[DataWidth-3:DataWidth-10];
  assign mir  = ~low;

  assign rom_low = $signed({1'b0, SinRom[low]});
  assign rom_mir = $signed({1'b0, SinRom[mir]});

  always_comb begin
    unique case (quad)
      QuadPosLow: begin
        sin_o = rom_low;
        cos_o = rom_mir;
      end
      QuadPosHigh: begin
        sin_o = rom_mir;
        cos_o = -rom_low;
      end
      QuadNegHigh: begin
        sin_o = -rom_low;
        cos_o = -rom_mir;
      end
      QuadNegLow: begin
        sin_o = -rom_mir;
        cos_o = rom_low;
      end
    endcase
  end

endmodule

[hdl/pipt_rotate.sv]
// rotation of a vector pair by sine and cosine, forward with saturation,
// inverse with wrap; depends on pipt_pkg

module pipt_rotate (
  input  pipt_pkg::pipt_kind_e                 kind_i,
  input  logic signed [pipt_pkg::DataWidth-1:0] a_i,
  input  logic signed [pipt_pkg::DataWidth-1:0] b_i,
  input  logic signed [pipt_pkg::DataWidth-1:0] sin_i,
  input  logic signed [pipt_pkg::DataWidth-1:0] cos_i,
  output pipt_pkg::pipt_out_t                  res_o
);
  import pipt_pkg::*;

  localparam int unsigned ProdWidth  = 2 * DataWidth;
  localparam int unsigned SumWidth   = ProdWidth + 1;
  localparam int unsigned ShiftWidth = SumWidth - (DataWidth - 1);

  localparam logic signed [ShiftWidth-1:0] SatPos = ShiftWidth'(32767);
  localparam logic signed [ShiftWidth-1:0] SatNeg = -ShiftWidth'(32767);

  logic signed [ProdWidth-1:0]  p_ac;
  logic signed [ProdWidth-1:0]  p_bs;
  logic signed [ProdWidth-1:0]  p_bc;
  logic signed [ProdWidth-1:0]  p_as;
  logic signed [SumWidth-1:0]   sum0;
  logic signed [SumWidth-1:0]   sum1;
  logic signed [ShiftWidth-1:0] sh0;
  logic signed [ShiftWidth-1:0] sh1;

  function automatic logic signed [DataWidth-1:0] sat_fwd(
    input logic signed [ShiftWidth-1:0] v
  );
    logic signed [ShiftWidth-1:0] r;
    r = v;
    if (v > SatPos) begin
      r = SatPos;
    end else if (v < SatNeg) begin
      r = SatNeg;
    end
    return r[DataWidth-1:0];
  endfunction

  assign p_ac = a_i * cos_i;
  assign p_bs = b_i * sin_i;
  assign p_bc = b_i * cos_i;
  assign p_as = a_i * sin_i;

  always_comb begin
    case (kind_i)
      KIND_FWD: begin
        sum0 = SumWidth'(p_ac) + SumWidth'(p_bs);
        sum1 = SumWidth'(p_bc) - SumWidth'(p_as);
      end
      default: begin
        sum0 = SumWidth'(p_ac) - SumWidth'(p_bs);
        sum1 = SumWidth'(p_as) + SumWidth'(p_bc);
      end
    endcase
  end

  // floor shift by 15 is the top bits of the sum
  assign sh0 = sum0[SumWidth-1:DataWidth-1];
  assign sh1 = sum1[SumWidth-1:DataWidth-1];

  always_comb begin
    if (kind_i == KIND_FWD) begin
      res_o.first_out  = sat_fwd(sh0);
      res_o.second_out = sat_fwd(sh1);
    end else begin
      res_o.first_out  = sh0[DataWidth-1:0];
      res_o.second_out = sh1[DataWidth-1:0];
    end
  end

endmodule

[hdl/park_inverse_park_transform_top.sv]
// Park / inverse Park rotation in Q1.15. One result per item; a new item is taken
// every cycle unless the result side stalls. One input register, then table
// lookup, four 16x16 multiplies, add and (forward only) saturate into the result
// register; inverse items wrap. Sustained rate is one item per clock unless the
// result side stalls, set by the single pass through that multiply-add path.
// Back-pressure on the result side holds the result register and, once it is
// full, the input register; no state outlives an item, no clearing pass.
// depends on pipt_pkg, pipt_sincos, pipt_rotate

module park_inverse_park_transform_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pipt_pkg::pipt_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pipt_pkg::pipt_out_t out_data_o
);
  import pipt_pkg::*;

  logic                        s1_valid_q;
  logic                        s1_valid_d;
  pipt_in_t                    s1_q;
  logic                        out_valid_q;
  logic                        out_valid_d;
  pipt_out_t                   out_q;
  pipt_kind_e                  out_kind_q;
  logic                        advance;
  logic                        in_xfer;
  logic signed [DataWidth-1:0] sin_v;
  logic signed [DataWidth-1:0] cos_v;
  pipt_out_t                   res;

  // result register free or being emptied this cycle
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign s1_valid_d  = in_xfer ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = advance ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= in_data_i;
    end
    if (advance && s1_valid_q) begin
      out_q      <= res;
      out_kind_q <= s1_q.kind;
    end
  end

  pipt_sincos u_sincos (
    .angle_i (s1_q.angle),
    .sin_o   (sin_v),
    .cos_o   (cos_v)
  );

  pipt_rotate u_rotate (
    .kind_i (s1_q.kind),
    .a_i    (s1_q.first_in),
    .b_i    (s1_q.second_in),
    .sin_i  (sin_v),
    .cos_i  (cos_v),
    .res_o  (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a held item stays put while the result side stalls
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_q))
    else $error("stage one item changed while stalled");

  // input transfer into a full stage only when that stage moves on
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && s1_valid_q |-> advance)
    else $error("stage one overwritten");

  // forward results never show the most negative code
  a_fwd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_kind_q == KIND_FWD |->
      out_q.first_out != -16'sd32768 && out_q.second_out != -16'sd32768)
    else $error("forward result out of range");

endmodule

[verif/tb_park_inverse_park_transform_top.sv]
`timescale 1ns / 1ps
// self-checking testbench for park_inverse_park_transform_top: edge cases, then random rotations
// under three idle mixes, checked against an in-bench q15 rotation predictor; uses pipt_pkg

module tb_park_inverse_park_transform_top;
  import pipt_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned PhaseItems  = 620;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned NumPhases   = 3;

  // quadrant codes of the 10-bit angle index
  localparam logic [1:0] QUAD_NEG_HI = 2'd0;  // -180..-90 deg
  localparam logic [1:0] QUAD_NEG_LO = 2'd1;  // -90..0 deg
  localparam logic [1:0] QUAD_POS_LO = 2'd2;  // 0..90 deg
  localparam logic [1:0] QUAD_POS_HI = 2'd3;  // 90..180 deg

  localparam logic [15:0] MinQ15 = 16'h8000;
  localparam logic [15:0] MaxQ15 = 16'h7FFF;
  localparam logic [15:0] Deg45  = 16'h2000;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  pipt_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  pipt_out_t out_data_o;

  int          sine_quarter [RomDepth];
  pipt_in_t    pending_vectors [$];
  pipt_out_t   expected_rotations [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;

  park_inverse_park_transform_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // quarter-wave sine in q15: taylor series evaluated in unsigned q62, round half up
  initial begin : build_sine_quarter
    logic [63:0]  step_q62;
    logic [63:0]  x;
    logic [63:0]  x_sq;
    logic [63:0]  term;
    logic [63:0]  acc;
    logic [63:0]  rounded;
    logic [63:0]  divisor;
    logic [127:0] prod;
    step_q62 = PiQ60 >> 7;
    for (int i = 0; i < int'(RomDepth); i++) begin
      x    = step_q62 * 64'(i);
      prod = {64'd0, x} * {64'd0, x};
      x_sq = prod[125:62];
      term = x;
      acc  = x;
      for (int k = 1; k <= 14; k++) begin
        divisor = 64'((2 * k) * (2 * k + 1));
        prod    = {64'd0, term} * {64'd0, x_sq};
        term    = prod[125:62] / divisor;
        acc     = (k % 2 == 1) ? acc - term : acc + term;
      end
      rounded = (acc + (64'd1 << 46)) >> 47;
      sine_quarter[i] = (rounded > 64'd32767) ? 32767 : int'(rounded);
    end
  end

  function automatic longint clamp_fwd(longint v);
    if (v > 32767) return 32767;
    if (v < -32767) return -32767;
    return v;
  endfunction

  function automatic pipt_out_t rotate_q15(pipt_in_t v);
    logic [9:0] idx;
    logic [7:0] lo;
    logic [7:0] mir;
    longint     a;
    longint     b;
    longint     s;
    longint     c;
    longint     r0;
    longint     r1;
    pipt_out_t  res;
    // offset angle by half a turn, then keep the top 10 bits
    idx = {~v.angle[15], v.angle[14:6]};
    lo  = idx[7:0];
    mir = 8'hFF - lo;
    case (idx[9:8])
      QUAD_POS_LO: begin s = sine_quarter[lo];   c = sine_quarter[mir];  end
      QUAD_POS_HI: begin s = sine_quarter[mir];  c = -sine_quarter[lo];  end
      QUAD_NEG_HI: begin s = -sine_quarter[lo];  c = -sine_quarter[mir]; end
      QUAD_NEG_LO: begin s = -sine_quarter[mir]; c = sine_quarter[lo];   end
    endcase
    a = v.first_in;
    b = v.second_in;
    if (v.kind == KIND_FWD) begin
      r0 = clamp_fwd((a * c + b * s) >>> 15);
      r1 = clamp_fwd((b * c - a * s) >>> 15);
    end else begin
      // inverse wraps, no saturation
      r0 = (a * c - b * s) >>> 15;
      r1 = (a * s + b * c) >>> 15;
    end
    res.first_out  = r0[15:0];
    res.second_out = r1[15:0];
    return res;
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return MinQ15;
      1:       return MaxQ15;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_vector(pipt_kind_e kind, logic [15:0] a, logic [15:0] b,
                              logic [15:0] ang);
    pipt_in_t v;
    v.kind      = kind;
    v.first_in  = a;
    v.second_in = b;
    v.angle     = ang;
    pending_vectors.push_back(v);
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // driver: present the next pending vector once the previous transfer is done
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        expected_rotations.push_back(rotate_q15(in_data_i));
      end
      if (pending_vectors.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data_i  <= pending_vectors.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor: check each result transfer against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    pipt_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_rotations.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing pending", out_data_o));
        end else begin
          want = expected_rotations.pop_front();
          if (out_data_o.first_out !== want.first_out) begin
            report_mismatch($sformatf("first_out got %h want %h",
                                      out_data_o.first_out, want.first_out));
          end
          if (out_data_o.second_out !== want.second_out) begin
            report_mismatch($sformatf("second_out got %h want %h",
                                      out_data_o.second_out, want.second_out));
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_park_inverse_park_transform_top: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned send_pct [NumPhases];
    int unsigned recv_pct [NumPhases];
    pipt_in_t    v;
    send_pct = '{35, 82, 0};
    recv_pct = '{82, 35, 0};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_idle_pct = send_pct[0];
    recv_idle_pct = recv_pct[0];

    // quadrant starts and the top of the angle range
    queue_vector(KIND_FWD, MaxQ15, MinQ15, MinQ15);
    queue_vector(KIND_INV, MinQ15, MaxQ15, MinQ15);
    queue_vector(KIND_FWD, MaxQ15, MaxQ15, 16'hC000);
    queue_vector(KIND_INV, MaxQ15, MaxQ15, 16'hC000);
    queue_vector(KIND_FWD, MinQ15, MaxQ15, 16'h0000);
    queue_vector(KIND_INV, MaxQ15, MinQ15, 16'h0000);
    queue_vector(KIND_FWD, 16'h4000, MinQ15, 16'h4000);
    queue_vector(KIND_INV, 16'h4000, MaxQ15, 16'h4000);
    queue_vector(KIND_FWD, MinQ15, MinQ15, MaxQ15);
    queue_vector(KIND_INV, MaxQ15, MaxQ15, MaxQ15);
    // forward saturation, the most negative value comes out as -32767
    queue_vector(KIND_FWD, MinQ15, MinQ15, Deg45);
    queue_vector(KIND_FWD, MaxQ15, MaxQ15, Deg45);
    queue_vector(KIND_FWD, MinQ15, MaxQ15, 16'hA000);
    // inverse overflow wraps
    queue_vector(KIND_INV, MaxQ15, MinQ15, Deg45);
    queue_vector(KIND_INV, MinQ15, MaxQ15, Deg45);
    queue_vector(KIND_INV, MinQ15, MinQ15, 16'hE000);
    // zeros and angles at the edges of table indices
    queue_vector(KIND_FWD, 16'h0000, 16'h0000, 16'h0000);
    queue_vector(KIND_INV, 16'h0000, 16'h0000, 16'hFFFF);
    queue_vector(KIND_FWD, 16'h1234, 16'hEDCB, 16'h003F);
    queue_vector(KIND_INV, 16'h1234, 16'hEDCB, 16'h0040);
    queue_vector(KIND_FWD, 16'hFFFF, 16'h0001, 16'hFFC0);

    for (int p = 0; p < int'(NumPhases); p++) begin
      while (pending_vectors.size() != 0) @(negedge clk_i);
      send_idle_pct = send_pct[p];
      recv_idle_pct = recv_pct[p];
      for (int n = 0; n < int'(PhaseItems); n++) begin
        v.kind      = pipt_kind_e'($urandom_range(0, 1));
        v.first_in  = pick_sample();
        v.second_in = pick_sample();
        v.angle     = ($urandom_range(0, 7) == 0) ? pick_sample() : 16'($urandom);
        pending_vectors.push_back(v);
      end
    end

    while (pending_vectors.size() != 0 || in_valid_i || expected_rotations.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);
    if (error_count == 0) begin
      $display("tb_park_inverse_park_transform_top: done, clean");
    end else begin
      $display("tb_park_inverse_park_transform_top: done, errors");
    end
    $finish;
  end

endmodule
